### rtl/core/bed_pkg.sv
`timescale 1ns / 1ps

package bed_pkg;

   localparam int NUM_BUTTONS            = 8;
   localparam int MAX_KEEPALIVE_PER_ITEM = 8;
   localparam int RESULT_LIMIT           = 8;
   localparam int KA_CAP  = (MAX_KEEPALIVE_PER_ITEM < RESULT_LIMIT) ?
                            MAX_KEEPALIVE_PER_ITEM : RESULT_LIMIT;
   localparam int BTN_W   = 3;
   localparam int KA_N_W  = $clog2(KA_CAP + 1);
   localparam int TIME_W  = 32;
   localparam int MS_W    = 16;
   localparam int CLICK_W = 8;
   localparam int KA_W    = 16;
   localparam int MODE_W  = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PRESS_DEB   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE_DEB = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CLICK_MIN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CLICK_MAX   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MULTI_GAP   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_KA_PERIOD   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_CLICKS  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_MODE        = 3'd7;

   // event kinds
   localparam logic [1:0] EV_PRESS     = 2'd0;
   localparam logic [1:0] EV_RELEASE   = 2'd1;
   localparam logic [1:0] EV_CLICK     = 2'd2;
   localparam logic [1:0] EV_KEEPALIVE = 2'd3;

   // datapath actions
   localparam logic [3:0] ACT_NONE     = 4'd0;
   localparam logic [3:0] ACT_LOAD     = 4'd1;
   localparam logic [3:0] ACT_CALC     = 4'd2;
   localparam logic [3:0] ACT_REARM    = 4'd3;
   localparam logic [3:0] ACT_LEVEL    = 4'd4;
   localparam logic [3:0] ACT_CLR      = 4'd5;
   localparam logic [3:0] ACT_PRESS    = 4'd6;
   localparam logic [3:0] ACT_KA       = 4'd7;
   localparam logic [3:0] ACT_REL      = 4'd8;
   localparam logic [3:0] ACT_RCOMMIT  = 4'd9;
   localparam logic [3:0] ACT_STORE    = 4'd10;
   localparam logic [3:0] ACT_STORE_LV = 4'd11;

   typedef struct packed {
      logic [3:0] act;
      logic       emit;
      logic [1:0] kind;
      logic       last;
   } bed_cmd_type;

   typedef struct packed {
      logic op;
      logic lv;
      logic armed;
      logic prev;
      logic press_sent;
      logic press_due;
      logic rel_due;
      logic pclick;
      logic ka_on;
      logic ka_go;
      logic ka_more;
      logic click1;
      logic click2;
      logic timeout;
      logic slot_free;
   } bed_sts_type;

endpackage

### rtl/core/bed_ctrl.sv
`timescale 1ns / 1ps

module bed_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  bed_pkg::bed_sts_type sts,
   output bed_pkg::bed_cmd_type cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CALC   = 4'd1;
   localparam logic [3:0] S_DECIDE = 4'd2;
   localparam logic [3:0] S_PCLICK = 4'd3;
   localparam logic [3:0] S_PRESS  = 4'd4;
   localparam logic [3:0] S_KA     = 4'd5;
   localparam logic [3:0] S_REL    = 4'd6;
   localparam logic [3:0] S_CLK1   = 4'd7;
   localparam logic [3:0] S_CLK2   = 4'd8;
   localparam logic [3:0] S_TCLICK = 4'd9;
   localparam logic [3:0] S_COMMIT = 4'd10;
   localparam logic [3:0] S_STORE  = 4'd11;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd.act    = bed_pkg::ACT_NONE;
      cmd.emit   = 1'b0;
      cmd.kind   = bed_pkg::EV_PRESS;
      cmd.last   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.act  = bed_pkg::ACT_LOAD;
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            cmd.act  = bed_pkg::ACT_CALC;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (sts.op) begin
               cmd.act  = bed_pkg::ACT_REARM;
               state_in = S_STORE;
            end else if (!sts.armed) begin
               state_in = S_STORE;
            end else if (sts.lv != sts.prev) begin
               cmd.act  = bed_pkg::ACT_LEVEL;
               state_in = S_COMMIT;
            end else if (sts.lv) begin
               if (!sts.press_sent) begin
                  if (sts.press_due) begin
                     state_in = sts.pclick ? S_PCLICK : S_PRESS;
                  end else begin
                     state_in = S_COMMIT;
                  end
               end else begin
                  state_in = sts.ka_on ? S_KA : S_COMMIT;
               end
            end else if (sts.press_sent) begin
               state_in = sts.rel_due ? S_REL : S_COMMIT;
            end else begin
               state_in = sts.timeout ? S_TCLICK : S_COMMIT;
            end
         end
         S_PCLICK: begin
            if (sts.slot_free) begin
               cmd.act  = bed_pkg::ACT_CLR;
               cmd.emit = 1'b1;
               cmd.kind = bed_pkg::EV_CLICK;
               state_in = S_PRESS;
            end
         end
         S_PRESS: begin
            if (sts.slot_free) begin
               cmd.act  = bed_pkg::ACT_PRESS;
               cmd.emit = 1'b1;
               cmd.kind = bed_pkg::EV_PRESS;
               cmd.last = 1'b1;
               state_in = S_COMMIT;
            end
         end
         S_KA: begin
            if (!sts.ka_go) begin
               state_in = S_COMMIT;
            end else if (sts.slot_free) begin
               cmd.act  = bed_pkg::ACT_KA;
               cmd.emit = 1'b1;
               cmd.kind = bed_pkg::EV_KEEPALIVE;
               cmd.last = !sts.ka_more;
               if (!sts.ka_more) begin
                  state_in = S_COMMIT;
               end
            end
         end
         S_REL: begin
            if (sts.slot_free) begin
               cmd.act  = bed_pkg::ACT_REL;
               cmd.emit = 1'b1;
               cmd.kind = bed_pkg::EV_RELEASE;
               cmd.last = !(sts.click1 || sts.click2);
               if (sts.click1) begin
                  state_in = S_CLK1;
               end else if (sts.click2) begin
                  state_in = S_CLK2;
               end else begin
                  state_in = S_COMMIT;
               end
            end
         end
         S_CLK1: begin
            if (sts.slot_free) begin
               cmd.act  = bed_pkg::ACT_RCOMMIT;
               cmd.emit = 1'b1;
               cmd.kind = bed_pkg::EV_CLICK;
               cmd.last = !sts.click2;
               state_in = sts.click2 ? S_CLK2 : S_COMMIT;
            end
         end
         S_CLK2, S_TCLICK: begin
            if (sts.slot_free) begin
               cmd.act  = bed_pkg::ACT_CLR;
               cmd.emit = 1'b1;
               cmd.kind = bed_pkg::EV_CLICK;
               cmd.last = 1'b1;
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.act  = bed_pkg::ACT_STORE_LV;
            state_in = S_IDLE;
         end
         S_STORE: begin
            cmd.act  = bed_pkg::ACT_STORE;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

### rtl/core/bed_dpath.sv
`timescale 1ns / 1ps

module bed_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [bed_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                req_tuser,
   input  logic                                csr_valid,
   input  logic [bed_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bed_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bed_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [1:0]                          rsp_tuser,
   output logic                                rsp_tlast,
   input  bed_pkg::bed_cmd_type                cmd,
   output bed_pkg::bed_sts_type                sts
);

   localparam int NB  = bed_pkg::NUM_BUTTONS;
   localparam int TW  = bed_pkg::TIME_W;
   localparam int MW  = bed_pkg::MS_W;
   localparam int CW  = bed_pkg::CLICK_W;
   localparam int KW  = bed_pkg::KA_W;
   localparam int NW  = bed_pkg::KA_N_W;
   localparam int BW  = bed_pkg::BTN_W;
   localparam logic [NW:0] CAP = (NW + 1)'(bed_pkg::KA_CAP);

   // configuration
   logic [MW-1:0] pdb_ff, rdb_ff, cmin_ff, cmax_ff, gap_ff, period_ff;
   logic [CW-1:0] maxc_ff;
   logic [bed_pkg::MODE_W-1:0] mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pdb_ff    <= MW'(20);
         rdb_ff    <= MW'(0);
         cmin_ff   <= MW'(20);
         cmax_ff   <= MW'(300);
         gap_ff    <= MW'(400);
         period_ff <= MW'(1000);
         maxc_ff   <= CW'(3);
         mode_ff   <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            bed_pkg::REG_PRESS_DEB:   pdb_ff    <= csr_data;
            bed_pkg::REG_RELEASE_DEB: rdb_ff    <= csr_data;
            bed_pkg::REG_CLICK_MIN:   cmin_ff   <= csr_data;
            bed_pkg::REG_CLICK_MAX:   cmax_ff   <= csr_data;
            bed_pkg::REG_MULTI_GAP:   gap_ff    <= csr_data;
            bed_pkg::REG_KA_PERIOD:   period_ff <= csr_data;
            bed_pkg::REG_MAX_CLICKS:  maxc_ff   <= csr_data[CW-1:0];
            bed_pkg::REG_MODE:        mode_ff   <= csr_data[bed_pkg::MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // per-button state store
   logic          st_prev_ff  [NB];
   logic          st_ps_ff    [NB];
   logic          st_armed_ff [NB];
   logic [TW-1:0] st_lct_ff   [NB];
   logic [TW-1:0] st_evt_ff   [NB];
   logic [TW-1:0] st_kat_ff   [NB];
   logic [KW-1:0] st_kac_ff   [NB];
   logic [CW-1:0] st_cc_ff    [NB];
   logic [TW-1:0] st_ckt_ff   [NB];

   // item and working copy
   logic          op_ff, lv_ff;
   logic [BW-1:0] b_ff;
   logic [TW-1:0] now_ff;
   logic          w_prev_ff, w_ps_ff, w_armed_ff;
   logic          w_prev_in, w_ps_in, w_armed_in;
   logic [TW-1:0] w_lct_ff, w_evt_ff, w_kat_ff, w_ckt_ff;
   logic [TW-1:0] w_lct_in, w_evt_in, w_kat_in, w_ckt_in;
   logic [KW-1:0] w_kac_ff, w_kac_in;
   logic [CW-1:0] w_cc_ff, w_cc_in;
   logic [TW-1:0] d_lc_ff, d_ev_ff, d_ck_ff, d_ka_ff;
   logic [TW-1:0] d_ka_in;
   logic [NW-1:0] n_ff, n_in;

   logic [BW-1:0] ridx;
   logic          store_en;
   logic          in_click, extend, click1, click2;
   logic [CW-1:0] new_cc;

   assign ridx     = req_tdata[BW-1:0];
   assign store_en = (cmd.act == bed_pkg::ACT_STORE) || (cmd.act == bed_pkg::ACT_STORE_LV);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NB; i++) begin
            st_prev_ff[i]  <= 1'b0;
            st_ps_ff[i]    <= 1'b0;
            st_armed_ff[i] <= 1'b0;
            st_lct_ff[i]   <= '0;
            st_evt_ff[i]   <= '0;
            st_kat_ff[i]   <= '0;
            st_kac_ff[i]   <= '0;
            st_cc_ff[i]    <= '0;
            st_ckt_ff[i]   <= '0;
         end
      end else if (store_en) begin
         st_prev_ff[b_ff]  <= (cmd.act == bed_pkg::ACT_STORE_LV) ? lv_ff : w_prev_ff;
         st_ps_ff[b_ff]    <= w_ps_ff;
         st_armed_ff[b_ff] <= w_armed_ff;
         st_lct_ff[b_ff]   <= w_lct_ff;
         st_evt_ff[b_ff]   <= w_evt_ff;
         st_kat_ff[b_ff]   <= w_kat_ff;
         st_kac_ff[b_ff]   <= w_kac_ff;
         st_cc_ff[b_ff]    <= w_cc_ff;
         st_ckt_ff[b_ff]   <= w_ckt_ff;
      end
   end

   // release planning
   assign in_click = (d_ev_ff >= TW'(cmin_ff)) && (d_ev_ff <= TW'(cmax_ff));
   assign extend   = (w_cc_ff != '0) && (w_cc_ff < maxc_ff) && (d_ck_ff < TW'(gap_ff));
   assign click1   = in_click ? (!extend && (w_cc_ff != '0))
                              : (mode_ff[1] && (w_cc_ff != '0) && (d_ev_ff < TW'(cmin_ff)));
   assign new_cc   = in_click ? (extend ? w_cc_ff + CW'(1) : CW'(1)) : '0;
   assign click2   = mode_ff[0] && (new_cc != '0) && (new_cc == maxc_ff);

   always_comb begin
      w_prev_in  = w_prev_ff;
      w_ps_in    = w_ps_ff;
      w_armed_in = w_armed_ff;
      w_lct_in   = w_lct_ff;
      w_evt_in   = w_evt_ff;
      w_kat_in   = w_kat_ff;
      w_kac_in   = w_kac_ff;
      w_cc_in    = w_cc_ff;
      w_ckt_in   = w_ckt_ff;
      d_ka_in    = d_ka_ff;
      n_in       = n_ff;
      unique case (cmd.act)
         bed_pkg::ACT_LOAD: begin
            w_prev_in  = st_prev_ff[ridx];
            w_ps_in    = st_ps_ff[ridx];
            w_armed_in = st_armed_ff[ridx];
            w_lct_in   = st_lct_ff[ridx];
            w_evt_in   = st_evt_ff[ridx];
            w_kat_in   = st_kat_ff[ridx];
            w_kac_in   = st_kac_ff[ridx];
            w_cc_in    = st_cc_ff[ridx];
            w_ckt_in   = st_ckt_ff[ridx];
         end
         bed_pkg::ACT_CALC: begin
            d_ka_in = now_ff - w_kat_ff;
            n_in    = '0;
            if (!op_ff && !w_armed_ff && !lv_ff) begin
               w_prev_in  = 1'b0;
               w_ps_in    = 1'b0;
               w_armed_in = 1'b1;
            end
         end
         bed_pkg::ACT_REARM: begin
            w_armed_in = 1'b0;
         end
         bed_pkg::ACT_LEVEL: begin
            w_lct_in = now_ff;
         end
         bed_pkg::ACT_CLR: begin
            w_cc_in = '0;
         end
         bed_pkg::ACT_PRESS: begin
            w_ps_in  = 1'b1;
            w_kat_in = now_ff;
            w_kac_in = '0;
            w_evt_in = now_ff;
         end
         bed_pkg::ACT_KA: begin
            w_kat_in = w_kat_ff + TW'(period_ff);
            w_kac_in = w_kac_ff + KW'(1);
            d_ka_in  = d_ka_ff - TW'(period_ff);
            n_in     = n_ff + NW'(1);
         end
         bed_pkg::ACT_REL: begin
            w_ps_in = 1'b0;
            if (!click1) begin
               w_cc_in  = new_cc;
               w_evt_in = now_ff;
               if (in_click) begin
                  w_ckt_in = now_ff;
               end
            end
         end
         bed_pkg::ACT_RCOMMIT: begin
            w_cc_in  = new_cc;
            w_evt_in = now_ff;
            if (in_click) begin
               w_ckt_in = now_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.act == bed_pkg::ACT_LOAD) begin
         op_ff  <= req_tuser;
         b_ff   <= req_tdata[BW-1:0];
         lv_ff  <= req_tdata[BW];
         now_ff <= req_tdata[BW+TW:BW+1];
      end
      if (cmd.act == bed_pkg::ACT_CALC) begin
         d_lc_ff <= now_ff - w_lct_ff;
         d_ev_ff <= now_ff - w_evt_ff;
         d_ck_ff <= now_ff - w_ckt_ff;
      end
      w_prev_ff  <= w_prev_in;
      w_ps_ff    <= w_ps_in;
      w_armed_ff <= w_armed_in;
      w_lct_ff   <= w_lct_in;
      w_evt_ff   <= w_evt_in;
      w_kat_ff   <= w_kat_in;
      w_kac_ff   <= w_kac_in;
      w_cc_ff    <= w_cc_in;
      w_ckt_ff   <= w_ckt_in;
      d_ka_ff    <= d_ka_in;
      n_ff       <= n_in;
   end

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0]                 rsp_id_ff;
   logic [1:0]                    rsp_kind_ff;
   logic [CW-1:0]                 rsp_cc_ff;
   logic [KW-1:0]                 rsp_ka_ff;
   logic                          rsp_last_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_id_ff   <= b_ff;
         rsp_kind_ff <= cmd.kind;
         rsp_cc_ff   <= w_cc_ff;
         rsp_ka_ff   <= (cmd.act == bed_pkg::ACT_KA) ? w_kac_ff + KW'(1) : w_kac_ff;
         rsp_last_ff <= cmd.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(bed_pkg::RSP_DATA_W - BW - CW - KW)'(0), rsp_ka_ff, rsp_cc_ff,
                        rsp_id_ff};

   // status to controller
   assign sts.op         = op_ff;
   assign sts.lv         = lv_ff;
   assign sts.armed      = w_armed_ff;
   assign sts.prev       = w_prev_ff;
   assign sts.press_sent = w_ps_ff;
   assign sts.press_due  = d_lc_ff >= TW'(pdb_ff);
   assign sts.rel_due    = d_lc_ff >= TW'(rdb_ff);
   assign sts.pclick     = !mode_ff[0] && (w_cc_ff != '0) && (w_cc_ff == maxc_ff);
   assign sts.ka_on      = period_ff != '0;
   assign sts.ka_go      = ({1'b0, n_ff} < CAP) && (d_ka_ff >= TW'(period_ff));
   assign sts.ka_more    = (({1'b0, n_ff} + (NW + 1)'(1)) < CAP) &&
                           ({1'b0, d_ka_ff} >= (TW + 1)'({period_ff, 1'b0}));
   assign sts.click1     = click1;
   assign sts.click2     = click2;
   assign sts.timeout    = (w_cc_ff != '0) && (d_ck_ff >= TW'(gap_ff));
   assign sts.slot_free  = !rsp_valid_ff || rsp_tready;

endmodule

### rtl/core/button_event_detector_top.sv
`timescale 1ns / 1ps

// Button event detector for eight buttons. Each request item samples one
// button's level at a wrapping millisecond time (tuser 0) or re-arms it
// (tuser 1); the block debounces presses and releases and answers with
// press, release, click and keep-alive event items, rsp_tlast marking the
// final event of a request. A request emits its events one per cycle while
// the output is taken (up to eight keep-alive events, two for a press,
// three for a release). Requests are handled one at a time: the
// per-button state is read once into a working copy, updated by a
// sequencer that emits events one by one through a single output register,
// and written back before the next request is taken. Registers are to be
// written through the csr port only while the block is idle; the block
// itself does not enforce this.

module button_event_detector_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bed_pkg::REQ_DATA_W-1:0]      req_tdata,  // button_index, level, now_ms
   input  logic                                req_tuser,  // op
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bed_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // button_id, click_total,
                                                           // keepalive_total
   output logic [1:0]                          rsp_tuser,  // event_kind
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bed_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bed_pkg::CSR_DATA_W-1:0]      csr_data
);

   bed_pkg::bed_cmd_type cmd;
   bed_pkg::bed_sts_type sts;

   assign csr_ready = 1'b1;

   bed_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bed_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .sts        (sts)
   );

`ifndef ASSERT_OFF
   a_no_emit_when_idle: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && cmd.emit))
      else $error("event emitted while accepting requests");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while previous one in work");

   a_valid_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.emit))
      else $error("result appeared without an emitted event");
`endif

endmodule
